/* design/plob_pkg.sv */
// Shared types and constants for the price-level order book.
// No dependencies.
package plob_pkg;

  localparam int PRICE_W    = 32;
  localparam int QTY_W      = 32;
  localparam int LQ_W       = 40;
  localparam int TIME_W     = 63;
  localparam int ONO_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_TRADE  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_PRICE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRICE_HIGH = 2'd1;

  localparam logic signed [LQ_W:0] QMAX = 41'sd549755813887;
  localparam logic signed [LQ_W:0] QMIN = -41'sd549755813888;

  function automatic logic signed [LQ_W-1:0] sat_qty(input logic signed [LQ_W:0] v);
    logic signed [LQ_W-1:0] r;
    if (v > QMAX) r = QMAX[LQ_W-1:0];
    else if (v < QMIN) r = QMIN[LQ_W-1:0];
    else r = v[LQ_W-1:0];
    return r;
  endfunction

endpackage

/* design/plob_if.sv */
// Channel interfaces for the order book: item input, result output, config writes.
// Depends on plob_pkg.
interface plob_in_if;
  import plob_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic                   side;
  logic [PRICE_W-1:0]     price;
  logic [QTY_W-1:0]       qty;
  logic [TIME_W-1:0]      event_time;
  logic [ONO_W-1:0]       order_no;
  logic [ONO_W-1:0]       bid_ref;
  logic [ONO_W-1:0]       offer_ref;
  modport source (output valid, mode, side, price, qty, event_time, order_no, bid_ref,
                  offer_ref, input ready);
  modport sink   (input valid, mode, side, price, qty, event_time, order_no, bid_ref,
                  offer_ref, output ready);
endinterface

interface plob_out_if;
  import plob_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic                     bid_valid;
  logic [PRICE_W-1:0]       bid_price;
  logic signed [LQ_W-1:0]   bid_qty;
  logic                     ask_valid;
  logic [PRICE_W-1:0]       ask_price;
  logic signed [LQ_W-1:0]   ask_qty;
  modport source (output valid, status, bid_valid, bid_price, bid_qty, ask_valid,
                  ask_price, ask_qty, input ready);
  modport sink   (input valid, status, bid_valid, bid_price, bid_qty, ask_valid,
                  ask_price, ask_qty, output ready);
endinterface

interface plob_cfg_if;
  import plob_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/price_level_order_book_unit.sv */
// Price-level order book top level: FSM, level quantity/time memories, order table.
// Depends on plob_pkg and the channel interfaces in plob_if.sv.
// Flow: add reads then writes its level; out-of-range or no-op goes straight to the result;
// cancel/trade looks up each nonzero reference in the order table and, on a hit, may scan levels.
// One item at a time; input ready again in the cycle after the result register loads,
// a result still held by the sink stalls the block in S_DONE. ORDER_SLOTS: power of two.
// Reset: clearing pass over max(LEVELS, ORDER_SLOTS) entries, input held off meanwhile.
module price_level_order_book_unit #(
  parameter int LEVELS      = 1024,
  parameter int ORDER_SLOTS = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  plob_in_if.sink      in_ch,
  plob_out_if.source   out_ch,
  plob_cfg_if.sink     cfg_ch
);
  import plob_pkg::*;

  localparam int LW    = $clog2(LEVELS);
  localparam int SW    = $clog2(ORDER_SLOTS);
  localparam int CLR_N = (LEVELS > ORDER_SLOTS) ? LEVELS : ORDER_SLOTS;
  localparam int CLR_W = $clog2(CLR_N + 1);

  typedef struct packed {
    logic             vld;
    logic             sell;
    logic [LW-1:0]    lvl;
    logic [ONO_W-1:0] tag;
  } slot_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_REF, S_ADD_RD, S_ADD_WR, S_LK_RD, S_LK_CK,
    S_Q_WR, S_SC_RD, S_SC_CK, S_NEXT, S_DONE
  } state_t;

  logic signed [LQ_W-1:0] qmem_b [LEVELS];
  logic signed [LQ_W-1:0] qmem_a [LEVELS];
  logic [63:0]            tmem_b [LEVELS];
  logic [63:0]            tmem_a [LEVELS];
  slot_t                  omem   [ORDER_SLOTS];

  state_t                 state_r;
  logic [CLR_W-1:0]       clr_r;
  logic [PRICE_W-1:0]     price_low_r, price_high_r;
  logic [1:0]             mode_r;
  logic                   side_r;
  logic [QTY_W-1:0]       qty_r;
  logic [TIME_W-1:0]      time_r;
  logic [ONO_W-1:0]       ono_r, bref_r, oref_r;
  logic                   status_r;
  logic [LW-1:0]          lvl_r, scan_k_r;
  logic [SW-1:0]          slot_r;
  logic                   bid_ok_r, ask_ok_r;
  logic [LW-1:0]          bid_best_r, ask_best_r;
  logic signed [LQ_W-1:0] bid_bq_r, ask_bq_r;
  logic                   out_valid_r, out_status_r, out_bv_r, out_av_r;
  logic [PRICE_W-1:0]     out_bp_r, out_ap_r;
  logic signed [LQ_W-1:0] out_bq_r, out_aq_r;

  logic signed [LQ_W-1:0] rd_b_r, rd_a_r;
  slot_t                  ot_rd_r;

  logic [LW-1:0]          q_raddr, q_waddr;
  logic                   q_we_b, q_we_a;
  logic signed [LQ_W-1:0] q_wdata;
  logic [63:0]            t_wdata;
  logic [SW-1:0]          o_raddr, o_waddr;
  logic                   o_we;
  slot_t                  o_wdata;

  logic                   in_acc, in_rng, out_load;
  logic [32:0]            hi_w, eff_w;
  logic [PRICE_W-1:0]     diff_w;
  logic [ONO_W-1:0]       cur_ref;
  logic signed [LQ_W-1:0] rd_cur, q_add, q_sub;
  logic signed [LQ_W:0]   ext_w, qx_w;
  logic                   hit;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign hi_w   = {1'b0, price_low_r} + 33'(LEVELS - 1);
  assign eff_w  = ({1'b0, price_high_r} < hi_w) ? {1'b0, price_high_r} : hi_w;
  assign in_rng = (in_ch.price >= price_low_r) && ({1'b0, in_ch.price} <= eff_w);
  assign diff_w = in_ch.price - price_low_r;

  assign cur_ref = side_r ? oref_r : bref_r;
  assign rd_cur  = side_r ? rd_a_r : rd_b_r;
  assign ext_w   = {rd_cur[LQ_W-1], rd_cur};
  assign qx_w    = $signed({{(LQ_W + 1 - QTY_W){1'b0}}, qty_r});
  assign q_add   = sat_qty(ext_w + qx_w);
  assign q_sub   = sat_qty(ext_w - qx_w);
  assign hit     = ot_rd_r.vld && (ot_rd_r.tag == cur_ref) && (ot_rd_r.sell == side_r);

  always_comb begin
    q_raddr = lvl_r;
    q_waddr = lvl_r;
    q_we_b  = 1'b0;
    q_we_a  = 1'b0;
    q_wdata = (mode_r == MODE_ADD) ? q_add : q_sub;
    t_wdata = {1'b0, time_r};
    o_raddr = slot_r;
    o_waddr = slot_r;
    o_we    = 1'b0;
    o_wdata = '{vld: 1'b1, sell: side_r, lvl: lvl_r, tag: ono_r};
    unique case (state_r)
      S_CLR: begin
        q_waddr = clr_r[LW-1:0];
        q_wdata = '0;
        t_wdata = '0;
        q_we_b  = (clr_r < CLR_W'(LEVELS));
        q_we_a  = (clr_r < CLR_W'(LEVELS));
        o_waddr = clr_r[SW-1:0];
        o_wdata = '0;
        o_we    = (clr_r < CLR_W'(ORDER_SLOTS));
      end
      S_LK_CK: q_raddr = ot_rd_r.lvl;
      S_ADD_WR: begin
        q_we_b = !side_r;
        q_we_a = side_r;
        o_we   = 1'b1;
      end
      S_Q_WR: begin
        q_we_b  = !side_r;
        q_we_a  = side_r;
        o_wdata = '0;
        o_we    = (q_sub <= 0);
      end
      S_SC_RD: q_raddr = scan_k_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we_b) begin
      qmem_b[q_waddr] <= q_wdata;
      tmem_b[q_waddr] <= t_wdata;
    end
    if (q_we_a) begin
      qmem_a[q_waddr] <= q_wdata;
      tmem_a[q_waddr] <= t_wdata;
    end
    rd_b_r <= qmem_b[q_raddr];
    rd_a_r <= qmem_a[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (o_we) omem[o_waddr] <= o_wdata;
    ot_rd_r <= omem[o_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      price_low_r  <= '0;
      price_high_r <= 32'd1023;
      bid_ok_r     <= 1'b0;
      ask_ok_r     <= 1'b0;
      bid_best_r   <= '0;
      ask_best_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_PRICE_LOW) price_low_r <= cfg_ch.data;
        else if (cfg_ch.index == REG_PRICE_HIGH) price_high_r <= cfg_ch.data;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CLR_W'(CLR_N - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            mode_r   <= in_ch.mode;
            qty_r    <= in_ch.qty;
            time_r   <= in_ch.event_time;
            ono_r    <= in_ch.order_no;
            bref_r   <= in_ch.bid_ref;
            oref_r   <= in_ch.offer_ref;
            lvl_r    <= diff_w[LW-1:0];
            unique case (mode_t'(in_ch.mode))
              MODE_ADD: begin
                side_r   <= in_ch.side;
                status_r <= !in_rng;
                if (!in_rng) begin
                  state_r <= S_DONE;
                end else begin
                  slot_r  <= in_ch.order_no[SW-1:0];
                  state_r <= S_ADD_RD;
                end
              end
              MODE_CANCEL: begin
                side_r   <= 1'b0;
                status_r <= 1'b0;
                state_r  <= S_REF;
              end
              MODE_TRADE: begin
                side_r   <= 1'b0;
                status_r <= !in_rng;
                state_r  <= in_rng ? S_REF : S_DONE;
              end
              MODE_NOP: begin
                status_r <= 1'b0;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_REF: begin
          if (cur_ref == '0) begin
            state_r <= S_NEXT;
          end else begin
            slot_r  <= cur_ref[SW-1:0];
            state_r <= S_LK_RD;
          end
        end
        S_ADD_RD: state_r <= S_ADD_WR;
        S_ADD_WR: begin
          if (!side_r) begin
            if (!bid_ok_r || lvl_r > bid_best_r) begin
              bid_ok_r   <= 1'b1;
              bid_best_r <= lvl_r;
              bid_bq_r   <= q_add;
            end else if (lvl_r == bid_best_r) begin
              bid_bq_r <= q_add;
            end
          end else begin
            if (!ask_ok_r || lvl_r < ask_best_r) begin
              ask_ok_r   <= 1'b1;
              ask_best_r <= lvl_r;
              ask_bq_r   <= q_add;
            end else if (lvl_r == ask_best_r) begin
              ask_bq_r <= q_add;
            end
          end
          state_r <= S_DONE;
        end
        S_LK_RD: state_r <= S_LK_CK;
        S_LK_CK: begin
          lvl_r   <= ot_rd_r.lvl;
          state_r <= hit ? S_Q_WR : S_NEXT;
        end
        S_Q_WR: begin
          scan_k_r <= lvl_r;
          if (mode_r == MODE_TRADE) begin
            if (q_sub > 0) begin
              state_r <= S_NEXT;
              if (side_r) begin
                ask_ok_r   <= 1'b1;
                ask_best_r <= lvl_r;
                ask_bq_r   <= q_sub;
              end else begin
                bid_ok_r   <= 1'b1;
                bid_best_r <= lvl_r;
                bid_bq_r   <= q_sub;
              end
            end else begin
              state_r <= S_SC_RD;
            end
          end else if (side_r ? (ask_ok_r && ask_best_r == lvl_r)
                              : (bid_ok_r && bid_best_r == lvl_r)) begin
            state_r <= S_SC_RD;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_SC_RD: state_r <= S_SC_CK;
        S_SC_CK: begin
          if (rd_cur > 0) begin
            state_r <= S_NEXT;
            if (side_r) begin
              ask_ok_r   <= 1'b1;
              ask_best_r <= scan_k_r;
              ask_bq_r   <= rd_cur;
            end else begin
              bid_ok_r   <= 1'b1;
              bid_best_r <= scan_k_r;
              bid_bq_r   <= rd_cur;
            end
          end else if (!side_r && scan_k_r == '0) begin
            bid_ok_r <= 1'b0;
            state_r  <= S_NEXT;
          end else if (side_r && scan_k_r == LW'(LEVELS - 1)) begin
            ask_ok_r <= 1'b0;
            state_r  <= S_NEXT;
          end else begin
            scan_k_r <= side_r ? scan_k_r + 1'b1 : scan_k_r - 1'b1;
            state_r  <= S_SC_RD;
          end
        end
        S_NEXT: begin
          if (!side_r) begin
            side_r  <= 1'b1;
            state_r <= S_REF;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_status_r <= status_r;
            out_bv_r     <= bid_ok_r;
            out_bp_r     <= bid_ok_r ? price_low_r + PRICE_W'(bid_best_r) : '0;
            out_bq_r     <= bid_ok_r ? bid_bq_r : '0;
            out_av_r     <= ask_ok_r;
            out_ap_r     <= ask_ok_r ? price_low_r + PRICE_W'(ask_best_r) : '0;
            out_aq_r     <= ask_ok_r ? ask_bq_r : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.bid_valid = out_bv_r;
  assign out_ch.bid_price = out_bp_r;
  assign out_ch.bid_qty   = out_bq_r;
  assign out_ch.ask_valid = out_av_r;
  assign out_ch.ask_price = out_ap_r;
  assign out_ch.ask_qty   = out_aq_r;

  a_clr_no_best: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !bid_ok_r && !ask_ok_r)
    else $error("best level valid during clearing pass");

  a_clr_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_ch.ready)
    else $error("input ready during clearing pass");

  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != S_IDLE)
    else $error("accepted beat did not start processing");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!out_valid_r || out_ch.ready) |=> out_valid_r)
    else $error("result not loaded");

endmodule
